// ===== rtl/core/gfc_pkg.sv =====
// ----------------------------------------------------------------------------
// gfc_pkg
// Types and constants shared by the frame compositor modules.
// ----------------------------------------------------------------------------
package gfc_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [1:0] {
    FUNC_HEADER = 2'd0,
    FUNC_PIXEL  = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    DISP_KEEP       = 2'd0,
    DISP_BACKGROUND = 2'd1,
    DISP_PREVIOUS   = 2'd2
  } disp_e;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_LOCATE,
    ST_FETCH,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic       first_frame;
    logic [7:0] rect_left;
    logic [7:0] rect_top;
    logic [8:0] rect_width;
    logic [8:0] rect_height;
    logic [8:0] transparent_index;
    logic [1:0] disposal_kind;
    logic [7:0] pixel_index;
    logic [7:0] read_x;
    logic [7:0] read_y;
  } in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       out_of_canvas;
  } out_t;

  typedef struct packed {
    logic [8:0] canvas_width;
    logic [8:0] canvas_height;
    logic [7:0] background_index;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic oob;
  } res_ctl_t;

endpackage

// ===== rtl/core/gfc_canvas_ram.sv =====
// ----------------------------------------------------------------------------
// gfc_canvas_ram
// Canvas store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gfc_canvas_ram import gfc_pkg::*; #(
  parameter int DEPTH = 65536,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [PIX_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [PIX_W-1:0] rdata_o
);

  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gfc_sequencer.sv =====
// ----------------------------------------------------------------------------
// gfc_sequencer
// Request sequencer: canvas walk for headers, locate/fetch/update for pixels
// and locate/fetch/result for reads, with separate walk and pixel addressing.
// ----------------------------------------------------------------------------
module gfc_sequencer import gfc_pkg::*; #(
  parameter int MAX_DIM       = 256,
  parameter int CANVAS_PIXELS = 65536,
  localparam int AW           = $clog2(CANVAS_PIXELS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  in_t              in_i,
  output logic             in_stall_o,
  input  cfg_t             cfg_i,
  input  logic             out_busy_i,
  output res_ctl_t         res_o,
  output logic             shown_we_o,
  output logic [AW-1:0]    shown_waddr_o,
  output logic [PIX_W-1:0] shown_wdata_o,
  output logic             shown_re_o,
  output logic [AW-1:0]    shown_raddr_o,
  input  logic [PIX_W-1:0] shown_rdata_i,
  output logic             saved_we_o,
  output logic [AW-1:0]    saved_waddr_o,
  output logic [PIX_W-1:0] saved_wdata_o,
  output logic             saved_re_o,
  output logic [AW-1:0]    saved_raddr_o,
  input  logic [PIX_W-1:0] saved_rdata_i
);

  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int EW   = (DimW > COORD_W) ? DimW : COORD_W;
  localparam int PW   = $clog2(MAX_DIM * MAX_DIM);
  localparam int XW   = ((PW > AW) ? PW : AW) + 1;

  state_e           state_q, state_d;
  logic             first_q, first_d;
  logic [7:0]       left_q, left_d;
  logic [7:0]       top_q, top_d;
  logic [8:0]       fw_q, fw_d;
  logic [8:0]       fh_q, fh_d;
  logic [8:0]       transp_q, transp_d;
  logic [1:0]       disp_q, disp_d;
  logic [8:0]       col_q, col_d;
  logic [8:0]       row_q, row_d;
  logic [EW-1:0]    x_q, x_d;
  logic [EW-1:0]    y_q, y_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic             is_read_q, is_read_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic             hit_q, hit_d;
  logic [EW-1:0]    wx_q, wx_d;
  logic [EW-1:0]    wy_q, wy_d;
  logic [XW-1:0]    base_q, base_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;

  logic [EW-1:0]    eff_w, eff_h;
  logic [XW-1:0]    walk_pos, pix_pos;
  logic             walk_ok, in_rng, walk_last, accept, opaque;
  logic [9:0]       col_inc;
  logic [PIX_W-1:0] new_pix;

  assign eff_w = (EW'(cfg_i.canvas_width) > EW'(MAX_DIM)) ? EW'(MAX_DIM)
                                                          : EW'(cfg_i.canvas_width);
  assign eff_h = (EW'(cfg_i.canvas_height) > EW'(MAX_DIM)) ? EW'(MAX_DIM)
                                                           : EW'(cfg_i.canvas_height);

  assign walk_pos  = base_q + XW'(wx_q);
  assign walk_ok   = walk_pos < XW'(CANVAS_PIXELS);
  assign walk_last = (wx_q == eff_w - EW'(1)) && (wy_q == eff_h - EW'(1));

  assign pix_pos = XW'(y_q) * XW'(MAX_DIM) + XW'(x_q);
  assign in_rng  = (x_q < eff_w) && (y_q < eff_h);

  assign col_inc = {1'b0, col_q} + 10'd1;
  assign opaque  = {1'b0, pix_q} != transp_q;
  assign new_pix = opaque ? pix_q : shown_rdata_i;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    left_d      = left_q;
    top_d       = top_q;
    fw_d        = fw_q;
    fh_d        = fh_q;
    transp_d    = transp_q;
    disp_d      = disp_q;
    col_d       = col_q;
    row_d       = row_q;
    x_d         = x_q;
    y_d         = y_q;
    pix_d       = pix_q;
    is_read_d   = is_read_q;
    addr_d      = addr_q;
    hit_d       = hit_q;
    wx_d        = wx_q;
    wy_d        = wy_q;
    base_d      = base_q;
    pend_d      = 1'b0;
    pend_addr_d = walk_pos[AW-1:0];

    res_o         = '0;
    shown_we_o    = 1'b0;
    shown_waddr_o = pend_addr_q;
    shown_wdata_o = saved_rdata_i;
    shown_re_o    = 1'b0;
    shown_raddr_o = addr_q;
    saved_we_o    = 1'b0;
    saved_waddr_o = walk_pos[AW-1:0];
    saved_wdata_o = cfg_i.background_index;
    saved_re_o    = 1'b0;
    saved_raddr_o = walk_pos[AW-1:0];

    if (pend_q) begin
      shown_we_o = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.func)
            FUNC_HEADER: begin
              first_d  = in_i.first_frame;
              left_d   = in_i.rect_left;
              top_d    = in_i.rect_top;
              fw_d     = in_i.rect_width;
              fh_d     = in_i.rect_height;
              transp_d = in_i.transparent_index;
              disp_d   = in_i.disposal_kind;
              col_d    = '0;
              row_d    = '0;
              wx_d     = '0;
              wy_d     = '0;
              base_d   = '0;
              if ((eff_w != '0) && (eff_h != '0)) begin
                state_d = ST_WALK;
              end
            end
            FUNC_PIXEL: begin
              if ((fw_q != '0) && (row_q < fh_q)) begin
                x_d       = EW'(left_q) + EW'(col_q);
                y_d       = EW'(top_q) + EW'(row_q);
                pix_d     = in_i.pixel_index;
                is_read_d = 1'b0;
                if (col_inc >= {1'b0, fw_q}) begin
                  col_d = '0;
                  row_d = row_q + 9'd1;
                end else begin
                  col_d = col_inc[8:0];
                end
                state_d = ST_LOCATE;
              end
            end
            FUNC_READ: begin
              x_d       = EW'(in_i.read_x);
              y_d       = EW'(in_i.read_y);
              is_read_d = 1'b1;
              state_d   = ST_LOCATE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (first_q) begin
          shown_we_o    = walk_ok;
          shown_waddr_o = walk_pos[AW-1:0];
          shown_wdata_o = cfg_i.background_index;
          saved_we_o    = walk_ok;
        end else begin
          saved_re_o = walk_ok;
          pend_d     = walk_ok;
        end
        if (wx_q == eff_w - EW'(1)) begin
          wx_d   = '0;
          wy_d   = wy_q + EW'(1);
          base_d = base_q + XW'(MAX_DIM);
        end else begin
          wx_d = wx_q + EW'(1);
        end
        if (walk_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      ST_LOCATE: begin
        hit_d  = in_rng && (pix_pos < XW'(CANVAS_PIXELS));
        addr_d = pix_pos[AW-1:0];
        if (in_rng && (pix_pos < XW'(CANVAS_PIXELS))) begin
          state_d = ST_FETCH;
        end else if (is_read_q) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FETCH: begin
        shown_re_o = 1'b1;
        state_d    = is_read_q ? ST_RESULT : ST_UPDATE;
      end
      ST_UPDATE: begin
        shown_we_o    = opaque;
        shown_waddr_o = addr_q;
        shown_wdata_o = pix_q;
        saved_we_o    = disp_q != DISP_PREVIOUS;
        saved_waddr_o = addr_q;
        saved_wdata_o = (disp_q == DISP_BACKGROUND) ? cfg_i.background_index : new_pix;
        state_d       = ST_IDLE;
      end
      ST_RESULT: begin
        if (!out_busy_i) begin
          res_o.load = 1'b1;
          res_o.oob  = !hit_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_q   <= 1'b0;
      left_q   <= '0;
      top_q    <= '0;
      fw_q     <= 9'd1;
      fh_q     <= 9'd1;
      transp_q <= 9'd256;
      disp_q   <= DISP_KEEP;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      left_q   <= left_d;
      top_q    <= top_d;
      fw_q     <= fw_d;
      fh_q     <= fh_d;
      transp_q <= transp_d;
      disp_q   <= disp_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    x_q         <= x_d;
    y_q         <= y_d;
    pix_q       <= pix_d;
    is_read_q   <= is_read_d;
    addr_q      <= addr_d;
    hit_q       <= hit_d;
    wx_q        <= wx_d;
    wy_q        <= wy_d;
    base_q      <= base_d;
    pend_addr_q <= pend_addr_d;
  end

endmodule

// ===== rtl/core/gif_frame_compositor_unit.sv =====
// ----------------------------------------------------------------------------
// gif_frame_compositor_unit
// Animated GIF frame compositor on an indexed canvas with frame disposal.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_i) takes one request at a time:
// a frame header, a raster pixel or a displayed-canvas read. Only a read
// produces a result on the output channel (out_valid_o / out_stall_i / out_o).
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken.
// Steps per request, counted from acceptance until the next one is taken:
//   header: a walk over W*H positions, with W, H the canvas size capped at
//           MAX_DIM; one canvas position per cycle through the walk address
//           counter, then a flush step
//   pixel : locate, read-modify of the displayed canvas, write; locate only
//           when the position falls outside the canvas
//   read  : locate, fetch, result (locate and result outside the canvas)
//   other : pixels past the rectangle and unused codes are taken and dropped
// The displayed and saved canvases are single-port-read memories; their
// contents are undefined after reset and are first set by a first-frame
// header. Reset clears control state and frame settings, not the canvases.
// A finished result waits in the output register while out_stall_i is high;
// a further read then waits until that register is taken.
// ----------------------------------------------------------------------------
module gif_frame_compositor_unit import gfc_pkg::*; #(
  parameter int MAX_DIM       = 256,
  parameter int CANVAS_PIXELS = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(CANVAS_PIXELS);

  cfg_t             cfg_q, cfg_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  res_ctl_t         res;
  logic             out_busy;

  logic             shown_we, shown_re, saved_we, saved_re;
  logic [AW-1:0]    shown_waddr, shown_raddr, saved_waddr, saved_raddr;
  logic [PIX_W-1:0] shown_wdata, shown_rdata, saved_wdata, saved_rdata;

  assign cfg_ready_o = 1'b1;
  assign out_busy    = out_valid_q && out_stall_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CANVAS_WIDTH:  cfg_d.canvas_width     = cfg_data_i;
        CFG_CANVAS_HEIGHT: cfg_d.canvas_height    = cfg_data_i;
        CFG_BACKGROUND:    cfg_d.background_index = cfg_data_i[PIX_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (res.load) begin
      out_valid_d         = 1'b1;
      out_d.out_of_canvas = res.oob;
      out_d.read_value    = res.oob ? '0 : shown_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.canvas_width     <= 9'd256;
      cfg_q.canvas_height    <= 9'd256;
      cfg_q.background_index <= '0;
      out_valid_q            <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  gfc_sequencer #(
    .MAX_DIM       (MAX_DIM),
    .CANVAS_PIXELS (CANVAS_PIXELS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_i          (in_i),
    .in_stall_o    (in_stall_o),
    .cfg_i         (cfg_q),
    .out_busy_i    (out_busy),
    .res_o         (res),
    .shown_we_o    (shown_we),
    .shown_waddr_o (shown_waddr),
    .shown_wdata_o (shown_wdata),
    .shown_re_o    (shown_re),
    .shown_raddr_o (shown_raddr),
    .shown_rdata_i (shown_rdata),
    .saved_we_o    (saved_we),
    .saved_waddr_o (saved_waddr),
    .saved_wdata_o (saved_wdata),
    .saved_re_o    (saved_re),
    .saved_raddr_o (saved_raddr),
    .saved_rdata_i (saved_rdata)
  );

  gfc_canvas_ram #(
    .DEPTH (CANVAS_PIXELS)
  ) u_shown (
    .clk_i   (clk_i),
    .we_i    (shown_we),
    .waddr_i (shown_waddr),
    .wdata_i (shown_wdata),
    .re_i    (shown_re),
    .raddr_i (shown_raddr),
    .rdata_o (shown_rdata)
  );

  gfc_canvas_ram #(
    .DEPTH (CANVAS_PIXELS)
  ) u_saved (
    .clk_i   (clk_i),
    .we_i    (saved_we),
    .waddr_i (saved_waddr),
    .wdata_i (saved_wdata),
    .re_i    (saved_re),
    .raddr_i (saved_raddr),
    .rdata_o (saved_rdata)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> !out_busy)
    else $error("result loaded over a stalled result");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.out_of_canvas) |-> (out_o.read_value == '0))
    else $error("out-of-canvas result carries a nonzero value");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_i.func == FUNC_READ)) |=> in_stall_o)
    else $error("read request did not hold the input channel");

endmodule
